// ----- design/sfbpw_pkg.sv -----
package sfbpw_pkg;

  typedef struct packed {
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic       pixel_on;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       last;
  } spi_out_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_e;

  // order of the four bytes sent per pixel
  typedef enum logic [1:0] {
    SEL_PAGE,
    SEL_COL_LOW,
    SEL_COL_HIGH,
    SEL_DATA
  } byte_sel_e;

  localparam logic [7:0] CMD_PAGE_BASE     = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW_MASK  = 8'h0F;
  localparam logic [7:0] CMD_COL_HIGH_BASE = 8'h10;
  localparam logic [4:0] COL_OFFSET_RESET  = 5'd18;

endpackage

// ----- design/shadow_framebuffer_pixel_writer_unit.sv -----
// Pixel writer for a page-addressed monochrome OLED with an on-chip shadow copy of the
// display memory (one byte per page and column, PAGE_COUNT * PANEL_WIDTH entries in a
// single-port-write, registered-read memory). After reset the block sweeps the memory
// to zero, one entry per cycle, and accepts no pixel until the sweep ends; the column offset
// register can be written at any time. A pixel outside the panel is taken and produces
// nothing. A pixel inside has its shadow byte read as it is taken, is updated and written
// back in the read state, and then goes out as four output transfers: page command, low
// column command, high column command and the updated byte as data (last set). The next
// pixel is taken together with the fourth transfer.
module shadow_framebuffer_pixel_writer_unit #(
  parameter int PANEL_WIDTH  = 96,
  parameter int PANEL_HEIGHT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sfbpw_pkg::pixel_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sfbpw_pkg::spi_out_t   out_data_o
);

  localparam int PAGE_COUNT   = (PANEL_HEIGHT + 7) / 8;
  localparam int SHADOW_DEPTH = PAGE_COUNT * PANEL_WIDTH;
  localparam int ADDR_W       = $clog2(SHADOW_DEPTH);

  sfbpw_pkg::state_e    state_q, state_d;
  sfbpw_pkg::byte_sel_e sel_q, sel_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;
  logic [4:0]           col_offset_q;

  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [7:0]           col_q, col_d;
  logic [2:0]           page_q, page_d;
  logic [2:0]           bit_q, bit_d;
  logic                 on_q, on_d;
  logic [7:0]           data_q, data_d;

  logic [7:0]           shadow_mem [SHADOW_DEPTH];
  logic [7:0]           rdata_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [7:0]           mem_wdata;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 in_range;
  logic [7:0]           mask;
  logic [7:0]           new_byte;

  assign in_range = (in_data_i.pixel_x < 8'(PANEL_WIDTH)) &&
                    (in_data_i.pixel_y < 8'(PANEL_HEIGHT));
  assign out_valid_o = (state_q == sfbpw_pkg::ST_SEND);
  assign out_xfer    = out_valid_o && out_ready_i;
  // next pixel rides on the last byte transfer
  assign in_ready_o  = (state_q == sfbpw_pkg::ST_IDLE) ||
                       (out_xfer && (sel_q == sfbpw_pkg::SEL_DATA));
  assign in_xfer     = in_valid_i && in_ready_o;

  assign mask     = 8'(1) << bit_q;
  assign new_byte = on_q ? (rdata_q | mask) : (rdata_q & ~mask);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    clr_d   = clr_q;
    addr_d  = ADDR_W'(int'(in_data_i.pixel_y[5:3]) * PANEL_WIDTH +
                      int'(in_data_i.pixel_x));
    col_d   = in_data_i.pixel_x + {3'b000, col_offset_q};
    page_d  = in_data_i.pixel_y[5:3];
    bit_d   = in_data_i.pixel_y[2:0];
    on_d    = in_data_i.pixel_on;
    data_d  = new_byte;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = new_byte;
    unique case (state_q)
      sfbpw_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = 8'h00;
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(SHADOW_DEPTH - 1)) begin
          state_d = sfbpw_pkg::ST_IDLE;
        end
      end
      sfbpw_pkg::ST_IDLE: begin
        if (in_xfer && in_range) begin
          state_d = sfbpw_pkg::ST_READ;
        end
      end
      sfbpw_pkg::ST_READ: begin
        mem_we  = 1'b1;
        sel_d   = sfbpw_pkg::SEL_PAGE;
        state_d = sfbpw_pkg::ST_SEND;
      end
      sfbpw_pkg::ST_SEND: begin
        if (out_xfer) begin
          unique case (sel_q)
            sfbpw_pkg::SEL_PAGE:     sel_d = sfbpw_pkg::SEL_COL_LOW;
            sfbpw_pkg::SEL_COL_LOW:  sel_d = sfbpw_pkg::SEL_COL_HIGH;
            sfbpw_pkg::SEL_COL_HIGH: sel_d = sfbpw_pkg::SEL_DATA;
            sfbpw_pkg::SEL_DATA: begin
              state_d = (in_xfer && in_range) ? sfbpw_pkg::ST_READ : sfbpw_pkg::ST_IDLE;
            end
            default: sel_d = sel_q;
          endcase
        end
      end
      default: state_d = sfbpw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sfbpw_pkg::ST_CLEAR;
      sel_q        <= sfbpw_pkg::SEL_PAGE;
      clr_q        <= '0;
      col_offset_q <= sfbpw_pkg::COL_OFFSET_RESET;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      clr_q   <= clr_d;
      if (cfg_we_i) begin
        col_offset_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      addr_q <= addr_d;
      col_q  <= col_d;
      page_q <= page_d;
      bit_q  <= bit_d;
      on_q   <= on_d;
    end
    if (state_q == sfbpw_pkg::ST_READ) begin
      data_q <= data_d;
    end
  end

  // shadow framebuffer, read issued on the accepting edge
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      shadow_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= shadow_mem[addr_d];
  end

  always_comb begin
    out_data_o.is_data = 1'b0;
    out_data_o.last    = 1'b0;
    unique case (sel_q)
      sfbpw_pkg::SEL_PAGE:     out_data_o.spi_byte = sfbpw_pkg::CMD_PAGE_BASE | {5'b00000, page_q};
      sfbpw_pkg::SEL_COL_LOW:  out_data_o.spi_byte = col_q & sfbpw_pkg::CMD_COL_LOW_MASK;
      sfbpw_pkg::SEL_COL_HIGH: out_data_o.spi_byte = sfbpw_pkg::CMD_COL_HIGH_BASE |
                                                     {4'b0000, col_q[7:4]};
      sfbpw_pkg::SEL_DATA: begin
        out_data_o.spi_byte = data_q;
        out_data_o.is_data  = 1'b1;
        out_data_o.last     = 1'b1;
      end
      default: out_data_o.spi_byte = data_q;
    endcase
  end

  // no pixel taken while the shadow memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sfbpw_pkg::ST_CLEAR) |-> !in_ready_o)
    else $error("pixel accepted during clearing pass");

  // an in-range pixel always goes to the read-modify-write step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_range) |=> (state_q == sfbpw_pkg::ST_READ))
    else $error("accepted pixel skipped shadow update");

  // after the data byte the block is idle or already on the next pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_data_o.last) |=>
      (state_q == sfbpw_pkg::ST_IDLE || state_q == sfbpw_pkg::ST_READ))
    else $error("byte sequence did not end after data byte");

endmodule
